// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the datapath, controller and top-level RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/bsb_pkg.sv =====
// Package with constants and types of the B-spline basis evaluator.
package bsb_pkg;
  localparam int MaxKnots  = 16;
  localparam int MaxDegree = 7;
  localparam int FracBits  = 16;
  localparam int KnotW     = 24;
  localparam int IdxW      = 4;
  localparam int DegW      = 3;
  localparam int KiuW      = 5;
  localparam int BasisW    = FracBits + 1;
  localparam int RowW      = 3;
  // Numerator: signed 25-bit difference times 17-bit basis.
  localparam int NumW      = 42;
  localparam int DivW      = 25;
  localparam int AccW      = 44;

  localparam logic [0:0] REQ_LOAD = 1'b0;
  localparam logic [0:0] REQ_EVAL = 1'b1;

  localparam logic [1:0] REG_DEGREE = 2'd0;
  localparam logic [1:0] REG_KNOTS  = 2'd1;

  localparam logic [DegW-1:0] DEGREE_RESET = 3'd3;
  localparam logic [KiuW-1:0] KNOTS_RESET  = 5'd8;

  typedef struct packed {
    logic            start;
    logic            init_row;
    logic            load_ops;
    logic            mul;
    logic            div_start;
    logic            term2;
    logic            write_row;
    logic [IdxW-1:0] i;
    logic [RowW-1:0] j;
    logic [RowW-1:0] d;
  } bsb_cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_zero;
  } bsb_stat_t;
endpackage

// ===== rtl/bsb_if.sv =====
// Valid/ready channel interfaces of the B-spline basis evaluator.
interface bsb_in_if import bsb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [0:0]        req_type;
  logic [IdxW-1:0]   knot_index;
  logic [KnotW-1:0]  knot_value;
  logic [KnotW-1:0]  param_u;
  modport source (output valid, req_type, knot_index, knot_value, param_u, input ready);
  modport sink   (input valid, req_type, knot_index, knot_value, param_u, output ready);
endinterface

interface bsb_out_if import bsb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BasisW-1:0] basis_value;
  logic              index_error;
  modport source (output valid, basis_value, index_error, input ready);
  modport sink   (input valid, basis_value, index_error, output ready);
endinterface

// ===== rtl/bsb_divider.sv =====
// Restoring serial divider, one quotient bit per cycle, truncating toward zero.
module bsb_divider import bsb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [NumW-1:0] num,
  input  logic signed [DivW-1:0] den,
  output logic                   done,
  output logic signed [NumW-1:0] quo
);
  localparam int CntW = $clog2(NumW + 1);
  logic [NumW-1:0] q;
  logic [DivW-1:0] rem;
  logic [DivW-1:0] dmag;
  logic            neg;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DivW:0]   trial;

  always_comb begin
    trial = {rem, q[NumW-1]} - {1'b0, dmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(NumW);
        neg  <= num[NumW-1] ^ den[DivW-1];
        q    <= num[NumW-1] ? NumW'(-num) : num;
        dmag <= den[DivW-1] ? DivW'(-den) : den;
        rem  <= '0;
      end else if (busy) begin
        if (!trial[DivW]) begin
          rem <= trial[DivW-1:0];
          q   <= {q[NumW-2:0], 1'b1};
        end else begin
          rem <= {rem[DivW-2:0], q[NumW-1]};
          q   <= {q[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? NumW'(-q) : q;
endmodule

// ===== rtl/bsb_datapath.sv =====
// Datapath: knot memory, work row, multiplier, divider and accumulator.
`include "assert_macros.svh"
module bsb_datapath import bsb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_we,
  input  logic [IdxW-1:0]   load_idx,
  input  logic [KnotW-1:0]  load_val,
  input  logic [KnotW-1:0]  u_in,
  input  bsb_cmd_t          cmd,
  output bsb_stat_t         stat,
  output logic [BasisW-1:0] row0
);
  localparam logic [BasisW-1:0] FixOne = BasisW'(1) << FracBits;

  logic [KnotW-1:0]  knot_table [MaxKnots];
  logic [BasisW-1:0] row [MaxDegree+1];
  logic [KnotW-1:0]  u;
  logic [KnotW-1:0]  ka, kb, kc, kd;
  logic signed [DivW-1:0]   diff_num, diff_den;
  logic [BasisW-1:0]        nsel;
  logic signed [NumW-1:0]   prod;
  logic signed [AccW-1:0]   acc;
  logic signed [NumW-1:0]   quo;
  logic                     div_done;
  logic [4:0]               a0, a1, a2, a3;

  // Knot addresses for entry j of degree d, base i+j.
  always_comb begin
    a0 = 5'(cmd.i) + 5'(cmd.j);
    a1 = a0 + 5'(cmd.d);
    a2 = a0 + 5'd1;
    a3 = a1 + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (load_we) knot_table[load_idx] <= load_val;
  end

  // Operands are fetched in one registered read step.
  always_ff @(posedge clk) begin
    if (cmd.start) u <= u_in;
    if (cmd.init_row || cmd.load_ops) begin
      ka <= knot_table[a0[IdxW-1:0]];
      kb <= cmd.init_row ? knot_table[a2[IdxW-1:0]] : knot_table[a1[IdxW-1:0]];
      kc <= knot_table[a2[IdxW-1:0]];
      kd <= knot_table[a3[IdxW-1:0]];
    end
  end

  always_comb begin
    if (!cmd.term2) begin
      diff_num = DivW'(u) - DivW'(ka);
      diff_den = DivW'(kb) - DivW'(ka);
      nsel     = row[cmd.j];
    end else begin
      diff_num = DivW'(kd) - DivW'(u);
      diff_den = DivW'(kd) - DivW'(kc);
      nsel     = row[cmd.j + 3'd1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= diff_num * $signed({1'b0, nsel});
  end

  bsb_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(prod), .den(diff_den),
    .done(div_done), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_ops && !cmd.term2) acc <= '0;
    else if (div_done && diff_den != '0) acc <= acc + AccW'(quo);
  end

  // Degree-0 row entry uses the half-open interval; higher entries saturate.
  always_ff @(posedge clk) begin
    if (cmd.write_row) begin
      if (cmd.d == '0)
        row[cmd.j] <= (ka <= u && u < kb) ? FixOne : '0;
      else if (acc < 0)
        row[cmd.j] <= '0;
      else if (acc > AccW'(FixOne))
        row[cmd.j] <= FixOne;
      else
        row[cmd.j] <= acc[BasisW-1:0];
    end
  end

  assign stat.div_done = div_done;
  assign stat.div_zero = (diff_den == '0);
  assign row0 = row[0];

  `ASSERT_CLK(a_write_sat, clk, rst,
    cmd.write_row |=> row[$past(cmd.j)] <= FixOne, "row entry above one")
  `ASSERT_CLK(a_div_not_mul, clk, rst, !(cmd.mul && div_done), "mul during divide")
  `ASSERT_CLK(a_init_ld, clk, rst, !(cmd.init_row && cmd.load_ops), "both fetches")
endmodule

// ===== rtl/bsb_ctrl.sv =====
// Controller state machine sequencing the triangle evaluation.
`include "assert_macros.svh"
module bsb_ctrl import bsb_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            eval_go,
  input  logic [IdxW-1:0] idx,
  input  logic [DegW-1:0] p,
  input  bsb_stat_t       stat,
  output bsb_cmd_t        cmd,
  output logic            busy,
  output logic            finish
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_F0    = 4'd1;
  localparam logic [3:0] S_W0    = 4'd2;
  localparam logic [3:0] S_FETCH = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_WAIT  = 4'd6;
  localparam logic [3:0] S_WR    = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]      state, state_next;
  logic [IdxW-1:0] i_r;
  logic [RowW-1:0] j, j_next, d, d_next;
  logic            t2, t2_next;

  always_comb begin
    state_next = state;
    j_next = j;
    d_next = d;
    t2_next = t2;
    cmd = '0;
    cmd.i = i_r;
    cmd.j = j;
    cmd.d = d;
    cmd.term2 = t2;
    cmd.start = eval_go && state == S_IDLE;
    finish = 1'b0;
    case (state)
      S_IDLE: if (eval_go) begin
        state_next = S_F0; j_next = '0; d_next = '0; t2_next = 1'b0;
      end
      S_F0: begin
        cmd.init_row = 1'b1; state_next = S_W0;
      end
      S_W0: begin
        cmd.write_row = 1'b1;
        if (j == p) begin
          if (p == '0) state_next = S_DONE;
          else begin
            d_next = 3'd1; j_next = '0; state_next = S_FETCH;
          end
        end else begin
          j_next = j + 3'd1; state_next = S_F0;
        end
      end
      S_FETCH: begin
        cmd.load_ops = 1'b1; state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1; state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1; state_next = S_WAIT;
      end
      S_WAIT: if (stat.div_done) begin
        if (!t2) begin
          t2_next = 1'b1; state_next = S_MUL;
        end else begin
          t2_next = 1'b0; state_next = S_WR;
        end
      end
      S_WR: begin
        cmd.write_row = 1'b1;
        if (j + d == p) begin
          if (d == p) state_next = S_DONE;
          else begin
            d_next = d + 3'd1; j_next = '0; state_next = S_FETCH;
          end
        end else begin
          j_next = j + 3'd1; state_next = S_FETCH;
        end
      end
      S_DONE: begin
        finish = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      j <= '0; d <= '0; t2 <= 1'b0;
    end else begin
      state <= state_next;
      j <= j_next; d <= d_next; t2 <= t2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) i_r <= idx;
  end

  assign busy = (state != S_IDLE);

  `ASSERT_CLK(a_fin_idle, clk, rst, finish |=> state == S_IDLE, "finish not to idle")
  `ASSERT_CLK(a_d_le_p, clk, rst, busy |-> d <= p, "degree beyond p")
  `ASSERT_CLK(a_go_idle, clk, rst, cmd.start |-> !busy, "start while busy")
endmodule

// ===== rtl/bspline_basis_eval.sv =====
// Top level of the B-spline basis evaluator.
// Evaluates N(i,p)(u) by the Cox-de Boor recurrence as a bottom-up triangle.
// Input channel: an item with req_type load writes one knot and
// produces no result. An item with req_type evaluate produces one result item
// with basis_value (unsigned Q1.16, saturated at 1.0) and index_error.
// Configuration: APB port, register 0 is spline_degree at 0x0, register 1 is
// knots_in_use at 0x4; write only while the block is idle.
// An out-of-range index is answered from the output register without starting
// the controller. Otherwise the degree-0 row is built first, and then each of
// the p(p+1)/2 higher entries takes two serial divides plus fetch and write;
// the serial divider dominates the evaluation time.
// One item is worked on at a time; the input takes a new item once the
// result register has been loaded and the previous result has been taken.
// A result waits in the output register while the receiver stalls; a load
// item is still accepted then. Reset restores the registers to degree 3 and
// eight knots and empties the output; the knot table is undefined until loaded.
`include "assert_macros.svh"
module bspline_basis_eval import bsb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  bsb_in_if.sink      in_ch,
  bsb_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [DegW-1:0] spline_degree;
  logic [KiuW-1:0] knots_in_use;
  logic [KiuW-1:0] knots_lim;
  logic            busy, finish, out_valid, eval_go, accept;
  bsb_cmd_t        cmd;
  bsb_stat_t       stat;
  logic [BasisW-1:0] row0;
  logic [5:0]      need;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      spline_degree <= DEGREE_RESET;
      knots_in_use  <= KNOTS_RESET;
    end else if (psel && penable && pwrite) begin
      case ({1'b0, paddr[2]})
        REG_DEGREE: spline_degree <= pwdata[DegW-1:0];
        REG_KNOTS:  knots_in_use  <= pwdata[KiuW-1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case ({1'b0, paddr[2]})
      REG_DEGREE: prdata = 32'(spline_degree);
      REG_KNOTS:  prdata = 32'(knots_in_use);
      default:    prdata = '0;
    endcase
  end

  // A knot count above the table size acts as the full table.
  assign knots_lim = (knots_in_use > KiuW'(MaxKnots)) ? KiuW'(MaxKnots) : knots_in_use;

  // Evaluations wait while busy or a result is unread; loads wait only on busy.
  assign in_ch.ready = !busy && !(in_ch.req_type == REQ_EVAL && out_valid);
  assign accept  = in_ch.valid && in_ch.ready;
  assign need    = 6'(in_ch.knot_index) + 6'(spline_degree) + 6'd2;
  assign eval_go = accept && in_ch.req_type == REQ_EVAL && need <= 6'(knots_lim);

  bsb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .eval_go(eval_go), .idx(in_ch.knot_index),
    .p(spline_degree), .stat(stat), .cmd(cmd), .busy(busy), .finish(finish)
  );

  bsb_datapath u_dp (
    .clk(clk), .rst(rst),
    .load_we(accept && in_ch.req_type == REQ_LOAD),
    .load_idx(in_ch.knot_index), .load_val(in_ch.knot_value),
    .u_in(in_ch.param_u), .cmd(cmd), .stat(stat), .row0(row0)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
      out_ch.basis_value <= row0;
      out_ch.index_error <= 1'b0;
    end else if (accept && in_ch.req_type == REQ_EVAL && !eval_go) begin
      out_valid <= 1'b1;
      out_ch.basis_value <= '0;
      out_ch.index_error <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end
  assign out_ch.valid = out_valid;

  `ASSERT_CLK(a_fin_free, clk, rst, finish |-> !out_valid, "result overwritten")
  `ASSERT_CLK(a_err_zero, clk, rst,
    out_valid && out_ch.index_error |-> out_ch.basis_value == '0, "error with value")
  `ASSERT_CLK(a_range, clk, rst,
    out_valid |-> out_ch.basis_value <= (BasisW'(1) << FracBits), "value above one")
endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the B-spline basis evaluator.
module tb_top;
  import bsb_pkg::*;

  typedef struct {
    logic [BasisW-1:0] basis;
    logic              err;
  } basis_result_t;

  // One row of the directed table. Rows with a typed-in answer have known set.
  typedef struct {
    logic [0:0]        req;
    logic [IdxW-1:0]   idx;
    logic [KnotW-1:0]  val;
    logic [KnotW-1:0]  u;
    bit                known;
    logic [BasisW-1:0] basis;
    logic              err;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bsb_in_if  in_ch ();
  bsb_out_if out_ch ();

  bspline_basis_eval DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Shadow copies of the knot table and the two registers.
  logic [KnotW-1:0] knot_shadow [MaxKnots];
  logic [DegW-1:0]  degree_shadow = DEGREE_RESET;
  logic [KiuW-1:0]  knots_shadow = KNOTS_RESET;

  // Register settings of the random phases.
  int degrees [10] = '{3, 0, 1, 7, 2, 5, 4, 6, 3, 1};
  int counts  [10] = '{8, 16, 2, 31, 0, 12, 16, 5, 20, 16};

  basis_result_t basis_expected [$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_range_errors = 0;
  bit gaps_on = 1'b1;

  // Bottom-up Cox-de Boor triangle over the shadow knots. Differences are
  // signed, quotients truncate toward zero, a zero divisor drops its term and
  // every entry is clamped to 0..1.0 before the next row uses it.
  function automatic basis_result_t eval_basis(logic [IdxW-1:0] i, logic [KnotW-1:0] u_in);
    basis_result_t res;
    longint row [MaxDegree+1];
    longint u, div1, div2, acc, lo, hi;
    int p, k, b;
    p = degree_shadow;
    k = (knots_shadow > MaxKnots) ? MaxKnots : knots_shadow;
    u = u_in;
    res.basis = '0;
    res.err = 1'b0;
    if (i + p + 2 > k) begin
      res.err = 1'b1;
      return res;
    end
    for (int j = 0; j <= p; j++) begin
      lo = knot_shadow[i+j];
      hi = knot_shadow[i+j+1];
      row[j] = (lo <= u && u < hi) ? (longint'(1) << FracBits) : 0;
    end
    for (int d = 1; d <= p; d++) begin
      for (int j = 0; j + d <= p; j++) begin
        b = i + j;
        div1 = longint'(knot_shadow[b+d]) - longint'(knot_shadow[b]);
        div2 = longint'(knot_shadow[b+d+1]) - longint'(knot_shadow[b+1]);
        acc = 0;
        if (div1 != 0) acc += ((u - longint'(knot_shadow[b])) * row[j]) / div1;
        if (div2 != 0) acc += ((longint'(knot_shadow[b+d+1]) - u) * row[j+1]) / div2;
        if (acc < 0) acc = 0;
        if (acc > (longint'(1) << FracBits)) acc = longint'(1) << FracBits;
        row[j] = acc;
      end
    end
    res.basis = row[0][BasisW-1:0];
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Send one item and keep the shadow state in step once it is accepted.
  // ready is looked at on the falling edge, where nothing is in motion.
  task automatic send_item(logic [0:0] req, logic [IdxW-1:0] idx, logic [KnotW-1:0] val,
                           logic [KnotW-1:0] u, bit known = 0,
                           logic [BasisW-1:0] basis = '0, logic err = 1'b0);
    int gap;
    basis_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.knot_index <= idx;
    in_ch.knot_value <= val;
    in_ch.param_u    <= u;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    n_items++;
    if (req == REQ_LOAD) begin
      knot_shadow[idx] = val;
    end else begin
      res = eval_basis(idx, u);
      if (known && (res.basis !== basis || res.err !== err)) begin
        $error("directed row disagrees with predictor: basis %0d/%0d err %0b/%0b",
               basis, res.basis, err, res.err);
        errors++;
      end
      if (known) begin
        res.basis = basis;
        res.err = err;
      end
      basis_expected.push_back(res);
    end
  endtask

  // Receiver: ready stalls at random while gaps are on and stays high otherwise;
  // results are compared on the falling edge before the rising edge that takes them.
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    if (!gaps_on) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 99) < 60) ||
                         ($urandom_range(0, 99) < 10 && out_ch.ready);
  end

  always @(negedge clk) begin
    basis_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (basis_expected.size() == 0) begin
        $error("result item with nothing expected: basis %0d err %0b",
               out_ch.basis_value, out_ch.index_error);
        errors++;
      end else begin
        want = basis_expected.pop_front();
        if (want.err) n_range_errors++;
        if (out_ch.basis_value !== want.basis) begin
          $error("basis_value expected %0d actual %0d", want.basis, out_ch.basis_value);
          errors++;
        end
        if (out_ch.index_error !== want.err) begin
          $error("index_error expected %0b actual %0b", want.err, out_ch.index_error);
          errors++;
        end
      end
    end
  end

  // Register write over the configuration port: setup cycle, then access.
  task automatic write_reg(logic [1:0] which, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which[0], 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (which == REG_DEGREE) degree_shadow = value[DegW-1:0];
    else knots_shadow = value[KiuW-1:0];
  endtask

  // Drain all results; a load leaves nothing to wait for, so idle cycles
  // follow before any register is touched.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    wait (basis_expected.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  // Rebuild the table as a nondecreasing sequence, with repeated knots now and
  // then so that zero-width spans appear.
  task automatic load_sorted_knots(bit wide);
    logic [KnotW-1:0] t;
    t = KnotW'($urandom_range(0, 4) << FracBits);
    for (int s = 0; s < MaxKnots; s++) begin
      send_item(REQ_LOAD, s[IdxW-1:0], t, KnotW'($urandom()));
      if ($urandom_range(0, 99) >= 15)
        t = t + KnotW'(wide ? $urandom_range(1, 24'hFFFFF) : $urandom_range(1, 24'h30000));
    end
  endtask

  directed_row_t directed [$];

  initial begin
    logic [KnotW-1:0] u;
    logic [IdxW-1:0] idx;

    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_LOAD;
    in_ch.knot_index = '0;
    in_ch.knot_value = '0;
    in_ch.param_u = '0;

    // Directed part, under the reset settings of degree 3 and eight knots.
    // Uniform knots t[s] = s first; the last slot then gets the largest value.
    for (int s = 0; s < MaxKnots; s++)
      directed.push_back('{REQ_LOAD, IdxW'(s), KnotW'(s << FracBits), 0, 0, 0, 0});
    directed.push_back('{REQ_LOAD, 15, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0});
    // Last index, and the first index past the range: both give an error.
    directed.push_back('{REQ_EVAL, 15, 0, 24'h018000, 1, 0, 1});
    directed.push_back('{REQ_EVAL, 4, 0, 24'h048000, 1, 0, 1});
    // Parameter at the left end of the support and at the top of the field: zero.
    directed.push_back('{REQ_EVAL, 0, 0, 24'h000000, 1, 0, 0});
    directed.push_back('{REQ_EVAL, 3, 0, 24'hFFFFFF, 1, 0, 0});
    // Inside the support, left to the predictor.
    directed.push_back('{REQ_EVAL, 0, 0, 24'h020000, 0, 0, 0});
    directed.push_back('{REQ_EVAL, 2, 0, 24'h038000, 0, 0, 0});
    directed.push_back('{REQ_EVAL, 3, 0, 24'h04FFFF, 0, 0, 0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[r])
      send_item(directed[r].req, directed[r].idx, directed[r].val, directed[r].u,
                directed[r].known, directed[r].basis, directed[r].err);

    // Random part: one phase per register setting.
    foreach (degrees[ph]) begin
      wait_idle();
      gaps_on = (ph % 4 != 2);
      write_reg(REG_DEGREE, degrees[ph]);
      write_reg(REG_KNOTS, counts[ph]);
      load_sorted_knots(ph % 3 == 1);
      for (int n = 0; n < 44; n++) begin
        if ($urandom_range(0, 99) < 15) begin
          // Noise: a stray load that may break the ordering of the knots.
          send_item(REQ_LOAD, IdxW'($urandom_range(0, 15)),
                    KnotW'($urandom_range(0, 24'hFFFFFF)), KnotW'($urandom()));
        end else begin
          idx = ($urandom_range(0, 99) < 80 && degrees[ph] < 14)
                ? IdxW'($urandom_range(0, 14 - degrees[ph])) : IdxW'($urandom_range(0, 15));
          if ($urandom_range(0, 99) < 10)
            u = KnotW'($urandom_range(0, 24'hFFFFFF));
          else
            u = KnotW'($urandom_range(knot_shadow[0], knot_shadow[15]));
          send_item(REQ_EVAL, idx, KnotW'($urandom_range(0, 24'hFFFFFF)), u);
        end
      end
    end

    wait_idle();
    $display("Ran %0d items over ten register settings, degree 0 to 7 and knot counts 0 to 31.",
             n_items);
    $display("Checked %0d results, %0d of them index errors.", n_results, n_range_errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #400_000_000;
    $display("Timeout with %0d results outstanding.", basis_expected.size());
    $display("*** FAILED ***");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bsb_pkg.sv
rtl/bsb_if.sv
rtl/bsb_divider.sv
rtl/bsb_datapath.sv
rtl/bsb_ctrl.sv
rtl/bspline_basis_eval.sv
bench/tb_top.sv
